@@ hdl/bvt_pkg.sv @@
// ----------------------------------------------------------------------------
// bvt_pkg: shared types and constants for the block variance threshold
// Field widths, register indexes and the records passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package bvt_pkg;

  localparam int GridColsMax = 64;
  localparam int ColW        = $clog2(GridColsMax);
  localparam int DimW        = 13;
  localparam int DimMax      = 4096;
  localparam int RowW        = 12;
  localparam int CellsAcW    = 7;
  localparam int DepthW      = 20;
  localparam int SumW        = 33;
  localparam int SqW         = 52;
  localparam int CntW        = 13;
  localparam int CellPixMax  = 4096;
  localparam int LimW        = 40;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 40;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_ACROSS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_DOWN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPREAD_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FAR_LIMIT    = 3'd5;

  // Running statistics of one grid column
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [SqW-1:0]  sq;
    logic [CntW-1:0] cnt;
  } acc_t;

  localparam int AccW = $bits(acc_t);

  // Finished cell waiting for the variance check
  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            last;
    acc_t            acc;
  } cell_t;

  // Clamped image and grid geometry
  typedef struct packed {
    logic [DimW-1:0]     w;
    logic [DimW-1:0]     h;
    logic [CellsAcW-1:0] c;
    logic [DimW-1:0]     r;
  } geom_t;

endpackage

`default_nettype wire

@@ hdl/bvt_ram.sv @@
// ----------------------------------------------------------------------------
// bvt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bvt_div.sv @@
// ----------------------------------------------------------------------------
// bvt_div: iterative restoring divider for the grid edge spacing
// One quotient bit per cycle; done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module bvt_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [bvt_pkg::DimW-1:0] a_i,
  input  wire logic [bvt_pkg::DimW-1:0] b_i,
  output logic      [bvt_pkg::DimW-1:0] q_o,
  output logic      [bvt_pkg::DimW-1:0] r_o,
  output logic                        done_o
);
  import bvt_pkg::*;

  localparam int StepW = $clog2(DimW);
  localparam logic [StepW-1:0] LastStep = StepW'(DimW - 1);

  logic             run_q, done_q;
  logic [StepW-1:0] step_q;
  logic [DimW-1:0]  rem_q, quo_q, den_q;
  logic [DimW:0]    trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[DimW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= a_i;
      rem_q <= '0;
      den_q <= b_i;
    end else if (run_q) begin
      rem_q <= fits ? DimW'(trial - {1'b0, den_q}) : trial[DimW-1:0];
      quo_q <= {quo_q[DimW-2:0], fits};
    end
  end

  assign q_o    = quo_q;
  assign r_o    = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ hdl/bvt_fifo.sv @@
// ----------------------------------------------------------------------------
// bvt_fifo: short queue of finished cells
// Decouples the pixel front end from the variance check.
// ----------------------------------------------------------------------------
`default_nettype none

module bvt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bvt_pkg::cell_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output bvt_pkg::cell_t      head_o
);
  import bvt_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  cell_t           mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rp_q];

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bvt_front.sv @@
// ----------------------------------------------------------------------------
// bvt_front: pixel front end
// Tracks the raster position, accumulates per-column statistics and
// pushes each finished cell into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bvt_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bvt_pkg::geom_t             geom_i,
  input  wire logic [bvt_pkg::DepthW-1:0] far_limit_i,
  input  wire logic                       restart_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bvt_pkg::DepthW-1:0] depth_i,
  output logic                            push_o,
  output bvt_pkg::cell_t                  push_data_o,
  input  wire logic                       full_i
);
  import bvt_pkg::*;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_COL  = 2'd1;
  localparam logic [1:0] G_ROW  = 2'd2;

  // Edge spacing setup
  logic [1:0]      gst_q;
  logic            gstart_q;
  logic [DimW-1:0] div_a, div_b, div_q, div_r;
  logic            div_done, busy;
  logic [DimW-1:0] cq_q, rq_q;
  logic [ColW-1:0] cr_q;
  logic [RowW-1:0] rr_q;

  assign div_a = (gst_q == G_COL) ? geom_i.w : geom_i.h;
  assign div_b = (gst_q == G_COL) ? DimW'(geom_i.c) : geom_i.r;
  assign busy  = gst_q != G_IDLE;

  bvt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gstart_q),
    .a_i     (div_a),
    .b_i     (div_b),
    .q_o     (div_q),
    .r_o     (div_r),
    .done_o  (div_done)
  );

  // Run column spacing, then row spacing, after reset or a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q    <= G_COL;
      gstart_q <= 1'b1;
    end else if (restart_i) begin
      gst_q    <= G_COL;
      gstart_q <= 1'b1;
    end else begin
      gstart_q <= 1'b0;
      if (div_done) begin
        case (gst_q)
          G_COL: begin
            gst_q    <= G_ROW;
            gstart_q <= 1'b1;
          end
          G_ROW:   gst_q <= G_IDLE;
          default: gst_q <= G_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done && gst_q == G_COL) begin
      cq_q <= div_q;
      cr_q <= div_r[ColW-1:0];
    end
    if (div_done && gst_q == G_ROW) begin
      rq_q <= div_q;
      rr_q <= div_r[RowW-1:0];
    end
  end

  // Raster position and cell edges
  logic [RowW-1:0] pcol_q, prow_q, grow_q;
  logic [ColW-1:0] gcol_q, ngcol;
  logic [DimW-1:0] cedge_q, redge_q;
  logic [ColW-1:0] crem_q;
  logic [RowW-1:0] rrem_q;
  logic [DimW-1:0] pc1, pr1;
  logic            take, cell_end, col_end, row_wrap, row_end, frame_end, last;
  logic [ColW:0]   csum;
  logic [DimW:0]   rsum;
  logic            cstep, rstep;
  logic            setup_done;

  assign in_ready_o = !busy && !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign setup_done = div_done && gst_q == G_ROW;

  assign pc1       = DimW'(pcol_q) + 1'b1;
  assign pr1       = DimW'(prow_q) + 1'b1;
  assign cell_end  = (pc1 == cedge_q) && (pr1 == redge_q);
  assign col_end   = pc1 >= cedge_q;
  assign row_wrap  = pc1 >= geom_i.w;
  assign row_end   = pr1 >= redge_q;
  assign frame_end = col_end && row_wrap && row_end && (pr1 >= geom_i.h);
  assign last      = (pc1 == geom_i.w) && (pr1 == geom_i.h);
  assign ngcol     = row_wrap ? '0 : gcol_q + 1'b1;

  assign csum  = {1'b0, crem_q} + {1'b0, cr_q};
  assign cstep = csum >= geom_i.c;
  assign rsum  = {2'b0, rrem_q} + {2'b0, rr_q};
  assign rstep = rsum >= {1'b0, geom_i.r};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q  <= '0;
      prow_q  <= '0;
      gcol_q  <= '0;
      grow_q  <= '0;
      cedge_q <= '0;
      crem_q  <= '0;
      redge_q <= '0;
      rrem_q  <= '0;
    end else if (setup_done) begin
      pcol_q  <= '0;
      prow_q  <= '0;
      gcol_q  <= '0;
      grow_q  <= '0;
      cedge_q <= cq_q;
      crem_q  <= cr_q;
      redge_q <= div_q;
      rrem_q  <= div_r[RowW-1:0];
    end else if (take) begin
      pcol_q <= pc1[RowW-1:0];
      if (col_end) begin
        gcol_q <= ngcol;
        // Next column edge: base on a new row, else step by w/c
        if (row_wrap) begin
          cedge_q <= cq_q;
          crem_q  <= cr_q;
        end else if (cstep) begin
          cedge_q <= cedge_q + cq_q + 1'b1;
          crem_q  <= ColW'(csum - (ColW+1)'(geom_i.c));
        end else begin
          cedge_q <= cedge_q + cq_q;
          crem_q  <= csum[ColW-1:0];
        end
        if (row_wrap) begin
          pcol_q <= '0;
          prow_q <= pr1[RowW-1:0];
          if (row_end) begin
            grow_q <= grow_q + 1'b1;
            if (frame_end) begin
              prow_q  <= '0;
              grow_q  <= '0;
              redge_q <= rq_q;
              rrem_q  <= rr_q;
            end else if (rstep) begin
              redge_q <= redge_q + rq_q + 1'b1;
              rrem_q  <= RowW'(rsum - {1'b0, geom_i.r});
            end else begin
              redge_q <= redge_q + rq_q;
              rrem_q  <= rsum[RowW-1:0];
            end
          end
        end
      end
    end
  end

  // Column statistics: current column in registers, others in RAM
  acc_t             acc_q, base, acc_new, wdata, rdata;
  logic             use_ram_q, rvld_q;
  logic [GridColsMax-1:0] vld_q;
  logic             pix_ok, we, re;
  logic [2*DepthW-1:0] dsq;

  assign base    = use_ram_q ? (rvld_q ? rdata : '0) : acc_q;
  assign pix_ok  = (depth_i != '0) && (depth_i < far_limit_i)
                   && (base.cnt < CntW'(CellPixMax));
  assign dsq     = (2*DepthW)'(depth_i) * (2*DepthW)'(depth_i);

  always_comb begin
    acc_new = base;
    if (pix_ok) begin
      acc_new.sum = base.sum + SumW'(depth_i);
      acc_new.sq  = base.sq + SqW'(dsq);
      acc_new.cnt = base.cnt + 1'b1;
    end
  end

  assign wdata = cell_end ? '0 : acc_new;
  assign we    = take && col_end;
  assign re    = we && !frame_end && (ngcol != gcol_q);

  bvt_ram #(
    .Width (AccW),
    .Depth (GridColsMax)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (gcol_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ngcol),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      use_ram_q <= 1'b0;
      rvld_q    <= 1'b0;
      vld_q     <= '0;
    end else if (restart_i || (take && frame_end)) begin
      acc_q     <= '0;
      use_ram_q <= 1'b0;
      rvld_q    <= 1'b0;
      vld_q     <= '0;
    end else if (take) begin
      if (col_end) begin
        vld_q[gcol_q] <= 1'b1;
        if (re) begin
          use_ram_q <= 1'b1;
          rvld_q    <= vld_q[ngcol];
        end else begin
          // Single grid column: the next column is this one
          acc_q     <= wdata;
          use_ram_q <= 1'b0;
        end
      end else begin
        acc_q     <= acc_new;
        use_ram_q <= 1'b0;
      end
    end
  end

  // Hand the finished cell to the queue
  assign push_o           = take && cell_end;
  assign push_data_o.x    = gcol_q;
  assign push_data_o.y    = grow_q;
  assign push_data_o.last = last;
  assign push_data_o.acc  = acc_new;

endmodule

`default_nettype wire

@@ hdl/bvt_check.sv @@
// ----------------------------------------------------------------------------
// bvt_check: cell variance check
// Tests count*sum_sq - sum^2 > limit*count^2 for cells of two or more pixels
// over the S_MUL and S_SUB steps of partial products, then loads the output
// register in S_CMP.
`default_nettype none

module bvt_check (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [bvt_pkg::LimW-1:0] limit_i,
  input  wire logic                     empty_i,
  input  wire bvt_pkg::cell_t           head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [bvt_pkg::ColW-1:0]      cell_x_o,
  output logic [bvt_pkg::RowW-1:0]      cell_y_o,
  output logic                          solid_o,
  output logic                          frame_done_o
);
  import bvt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUB  = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  localparam int WideW = 66;
  localparam int SqLoW = 26;
  localparam int SLoW  = 16;
  localparam int LLoW  = 20;

  logic [1:0]  step_q;
  cell_t       cell_q;
  logic [38:0] m0_q, m1_q;
  logic [49:0] m2_q, m3_q;
  logic [25:0] nn_q;
  logic [45:0] l0_q, l1_q;
  logic [WideW-1:0] lhs_q, pa, pb, rhs;
  logic        out_valid_q, load_out, solid;

  assign pop_o    = (step_q == S_IDLE) && !empty_i;
  assign load_out = (step_q == S_CMP) && (!out_valid_q || out_ready_i);

  // Step through the check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      case (step_q)
        S_IDLE:  if (!empty_i) step_q <= S_MUL;
        S_MUL:   step_q <= S_SUB;
        S_SUB:   step_q <= S_CMP;
        S_CMP:   if (load_out) step_q <= S_IDLE;
        default: step_q <= S_IDLE;
      endcase
    end
  end

  // Partial products, one multiply level per step
  assign pa  = WideW'(m0_q) + (WideW'(m1_q) << SqLoW);
  assign pb  = (WideW'(m2_q) << SLoW) + WideW'(m3_q);
  assign rhs = WideW'(l0_q) + (WideW'(l1_q) << LLoW);
  assign solid = (cell_q.acc.cnt >= CntW'(2)) && (lhs_q > rhs);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cell_q <= head_i;
    end
    if (step_q == S_MUL) begin
      m0_q <= 39'(cell_q.acc.cnt) * 39'(cell_q.acc.sq[SqLoW-1:0]);
      m1_q <= 39'(cell_q.acc.cnt) * 39'(cell_q.acc.sq[SqW-1:SqLoW]);
      m2_q <= 50'(cell_q.acc.sum[SumW-1:SLoW]) * 50'(cell_q.acc.sum);
      m3_q <= 50'(cell_q.acc.sum[SLoW-1:0]) * 50'(cell_q.acc.sum);
      nn_q <= 26'(cell_q.acc.cnt) * 26'(cell_q.acc.cnt);
    end
    if (step_q == S_SUB) begin
      lhs_q <= pa - pb;
      l0_q  <= 46'(limit_i[LLoW-1:0]) * 46'(nn_q);
      l1_q  <= 46'(limit_i[LimW-1:LLoW]) * 46'(nn_q);
    end
    if (load_out) begin
      cell_x_o     <= cell_q.x;
      cell_y_o     <= cell_q.y;
      solid_o      <= solid;
      frame_done_o <= cell_q.last;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/depth_block_variance_threshold.sv @@
// ----------------------------------------------------------------------------
// depth_block_variance_threshold: solid-cell detection on a depth stream
// Depth pixels enter in raster order on the in channel (valid/ready). The
// image is tiled into a grid of cells; one item leaves on the out channel
// for every finished cell, carrying its grid position, the solid flag and
// a frame-done flag on the image's last cell.
// Throughput: one pixel per cycle while in_ready is high. The variance
// check runs in a separate unit that takes one cell at a time (queue pop,
// two multiply steps, and the compare with the output load); a four-entry
// cell queue sits between the pixel front end and the check, so pixels
// keep flowing unless cells finish faster than the check takes them, in
// which case in_ready drops while the queue is full.
// Result path: a finished cell goes through the queue and the check's
// S_IDLE, S_MUL, S_SUB and S_CMP steps into the output register; each cell
// still queued ahead of it is checked first.
// Reset, and every write to a register, restart the frame at pixel (0,0)
// and recompute the cell spacing in an iterative divider; in_ready stays
// low until both divisions finish. The cfg channel is always ready.
// When the receiver stalls, the result holds in the output register, the
// check stops and the queue fills; the front end then holds in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_block_variance_threshold (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bvt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bvt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bvt_pkg::DepthW-1:0]   depth_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [bvt_pkg::ColW-1:0]     cell_x_o,
  output logic      [bvt_pkg::RowW-1:0]     cell_y_o,
  output logic                              solid_o,
  output logic                              frame_done_o
);
  import bvt_pkg::*;

  logic [DimW-1:0]     width_q, height_q, down_q;
  logic [CellsAcW-1:0] across_q;
  logic [LimW-1:0]     spread_q;
  logic [DepthW-1:0]   far_q;
  logic                cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i
                       && (cfg_index_i inside {[CFG_IMAGE_WIDTH:CFG_FAR_LIMIT]});

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      across_q <= CellsAcW'(32);
      down_q   <= DimW'(24);
      spread_q <= '0;
      far_q    <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        CFG_CELLS_ACROSS: across_q <= cfg_data_i[CellsAcW-1:0];
        CFG_CELLS_DOWN:   down_q   <= cfg_data_i[DimW-1:0];
        CFG_SPREAD_LIMIT: spread_q <= cfg_data_i[LimW-1:0];
        CFG_FAR_LIMIT:    far_q    <= cfg_data_i[DepthW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry into its legal ranges
  geom_t           geom;
  logic [CellsAcW-1:0] cmax;

  always_comb begin
    geom.w = (width_q == '0) ? DimW'(1)
           : ((width_q > DimW'(DimMax)) ? DimW'(DimMax) : width_q);
    geom.h = (height_q == '0) ? DimW'(1)
           : ((height_q > DimW'(DimMax)) ? DimW'(DimMax) : height_q);
    cmax   = (geom.w < DimW'(GridColsMax)) ? geom.w[CellsAcW-1:0]
                                           : CellsAcW'(GridColsMax);
    geom.c = (across_q == '0) ? CellsAcW'(1)
           : ((across_q > cmax) ? cmax : across_q);
    geom.r = (down_q == '0) ? DimW'(1)
           : ((down_q > geom.h) ? geom.h : down_q);
  end

  cell_t push_data, head;
  logic  push, full, pop, empty;

  bvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .far_limit_i (far_q),
    .restart_i   (cfg_hit),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .depth_i     (depth_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  bvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  bvt_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (spread_q),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .solid_o      (solid_o),
    .frame_done_o (frame_done_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_depth_block_variance_threshold.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_block_variance_threshold: self-checking bench for the depth block
// variance threshold.
// A short table of directed pixels and register writes is followed by random
// frames over many small image and grid geometries. Each accepted pixel runs
// through a cycle-free model of the cell statistics. Each reported cell is
// compared against the oldest predicted cell, field by field.
// ----------------------------------------------------------------------------

module tb_depth_block_variance_threshold;
  import bvt_pkg::*;

  localparam int ClkHalf     = 10;
  localparam int WatchLimit  = 5000;
  localparam int SettleCyc   = 20;
  localparam int RandomItems = 1950;
  localparam int HoldOffCyc  = 400;

  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            solid;
    logic            done;
  } cell_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [DepthW-1:0]    depth;
    bit                   typed;
    cell_res_t            want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [DepthW-1:0]   depth_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ColW-1:0]     cell_x_o;
  logic [RowW-1:0]     cell_y_o;
  logic                solid_o;
  logic                frame_done_o;

  depth_block_variance_threshold i_dut (.*);

  always #(ClkHalf) clk_i = ~clk_i;

  // Model registers and frame state
  logic [DimW-1:0]     m_width, m_height, m_down;
  logic [CellsAcW-1:0] m_across;
  logic [LimW-1:0]     m_spread;
  logic [DepthW-1:0]   m_far;
  int unsigned pix_col, pix_row, grd_col, grd_row;
  int unsigned col_edge, row_edge;
  logic [63:0] col_sum [GridColsMax];
  logic [63:0] col_sq  [GridColsMax];
  int unsigned col_cnt [GridColsMax];

  cell_res_t   pending_cells[$];
  int          errors = 0;
  int          cells_seen = 0;
  int          pixels_sent = 0;
  int          phases_run = 0;
  bit          burst_mode = 1'b0;
  bit          held_off = 1'b0;

  // Clamp the registers into a usable geometry
  function automatic void clamp_geom(output int unsigned w, output int unsigned h,
                                     output int unsigned c, output int unsigned r);
    int unsigned cmax;
    w = (m_width == 0) ? 1 : (m_width > DimMax) ? DimMax : m_width;
    h = (m_height == 0) ? 1 : (m_height > DimMax) ? DimMax : m_height;
    cmax = (w < GridColsMax) ? w : GridColsMax;
    c = (m_across == 0) ? 1 : (m_across > cmax) ? cmax : m_across;
    r = (m_down == 0) ? 1 : (m_down > h) ? h : m_down;
  endfunction

  function automatic void restart_frame();
    int unsigned w, h, c, r;
    clamp_geom(w, h, c, r);
    pix_col = 0;
    pix_row = 0;
    grd_col = 0;
    grd_row = 0;
    col_edge = w / c;
    row_edge = h / r;
    for (int i = 0; i < GridColsMax; i++) begin
      col_sum[i] = '0;
      col_sq[i]  = '0;
      col_cnt[i] = 0;
    end
  endfunction

  // Variance test n*sq - s^2 > limit*n^2, from the quotient and remainder of lhs/n^2
  function automatic bit spread_exceeds(logic [63:0] s, logic [63:0] sq, int unsigned n);
    logic [63:0] lhs, n2, quo, rmd;
    if (n < 2) return 1'b0;
    lhs = 64'(n) * sq - s * s;
    n2  = 64'(n) * 64'(n);
    quo = lhs / n2;
    rmd = lhs % n2;
    if (quo != 64'(m_spread)) return quo > 64'(m_spread);
    return rmd != 0;
  endfunction

  // Advance the model by one pixel; return 1 when a cell finishes
  function automatic bit predict_pixel(logic [DepthW-1:0] d, output cell_res_t res);
    int unsigned w, h, c, r, gc;
    bit          hit;
    clamp_geom(w, h, c, r);
    gc = grd_col % GridColsMax;
    hit = 1'b0;
    res = '0;
    if (d != 0 && d < m_far && col_cnt[gc] < CellPixMax) begin
      col_sum[gc] += 64'(d);
      col_sq[gc]  += 64'(d) * 64'(d);
      col_cnt[gc]++;
    end
    if (pix_col + 1 == col_edge && pix_row + 1 == row_edge) begin
      res.x     = grd_col[ColW-1:0];
      res.y     = grd_row[RowW-1:0];
      res.solid = spread_exceeds(col_sum[gc], col_sq[gc], col_cnt[gc]);
      res.done  = (pix_col + 1 == w) && (pix_row + 1 == h);
      col_sum[gc] = '0;
      col_sq[gc]  = '0;
      col_cnt[gc] = 0;
      hit = 1'b1;
    end
    pix_col++;
    if (pix_col >= col_edge) begin
      grd_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        grd_col = 0;
        pix_row++;
        if (pix_row >= row_edge) begin
          grd_row++;
          if (pix_row >= h) begin
            restart_frame();
            return hit;
          end
          row_edge = ((grd_row + 1) * h) / r;
        end
      end
      col_edge = ((grd_col + 1) * w) / c;
    end
    return hit;
  endfunction

  // Drain every pending cell, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_cells.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_IMAGE_WIDTH:  m_width  = data[DimW-1:0];
      CFG_IMAGE_HEIGHT: m_height = data[DimW-1:0];
      CFG_CELLS_ACROSS: m_across = data[CellsAcW-1:0];
      CFG_CELLS_DOWN:   m_down   = data[DimW-1:0];
      CFG_SPREAD_LIMIT: m_spread = data[LimW-1:0];
      CFG_FAR_LIMIT:    m_far    = data[DepthW-1:0];
      default: ;
    endcase
    restart_frame();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one pixel, hold it until accepted, and log the predicted cell
  task automatic send_pixel(logic [DepthW-1:0] d, bit typed, cell_res_t want);
    int        gap;
    cell_res_t res;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    depth_i    = d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixels_sent++;
    if (predict_pixel(d, res)) begin
      pending_cells.push_back(res);
      if (typed && res != want) begin
        $error("directed cell: expected %h, model gives %h", want, res);
        errors++;
      end
    end else if (typed) begin
      $error("directed cell: expected %h, model gives none", want);
      errors++;
    end
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off, compare each cell
  initial begin : receive_cells
    int        wait_cyc;
    cell_res_t exp_c;
    @(posedge rst_ni);
    forever begin
      wait_cyc = burst_mode ? 0 : $urandom_range(0, 7);
      if (!held_off && cells_seen == 40) begin
        held_off = 1'b1;
        wait_cyc = HoldOffCyc;
      end
      if (wait_cyc > 0) begin
        out_ready_i = 1'b0;
        repeat (wait_cyc) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      cells_seen++;
      if (pending_cells.size() == 0) begin
        $error("unexpected cell x=%0d y=%0d", cell_x_o, cell_y_o);
        errors++;
      end else begin
        exp_c = pending_cells.pop_front();
        if (cell_x_o !== exp_c.x) begin
          $error("cell_x: expected %0d, got %0d", exp_c.x, cell_x_o);
          errors++;
        end
        if (cell_y_o !== exp_c.y) begin
          $error("cell_y: expected %0d, got %0d", exp_c.y, cell_y_o);
          errors++;
        end
        if (solid_o !== exp_c.solid) begin
          $error("solid: expected %0d, got %0d", exp_c.solid, solid_o);
          errors++;
        end
        if (frame_done_o !== exp_c.done) begin
          $error("frame_done: expected %0d, got %0d", exp_c.done, frame_done_o);
          errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: count cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchLimit) begin
        $display("watchdog expired with %0d cells pending", pending_cells.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.data   = data;
    return p;
  endfunction

  function automatic plan_row_t pix_entry(logic [DepthW-1:0] d, bit typed,
                                          cell_res_t want = '0);
    plan_row_t p;
    p = '{default: '0};
    p.depth = d;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  // Main stimulus
  initial begin : stimulus
    plan_row_t   plan[$];
    int unsigned w, h, ca, cd, k, n_pix, base, sh;
    logic [63:0] r64;
    logic [DepthW-1:0] d;

    m_width  = 13'd640;
    m_height = 13'd480;
    m_across = 7'd32;
    m_down   = 13'd24;
    m_spread = '0;
    m_far    = 20'hFFFFF;
    restart_frame();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: 2x2 single cell, extreme depths, threshold extremes, 1x1 image
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 40'd2));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 40'd2));
    plan.push_back(cfg_row(CFG_CELLS_ACROSS, 40'd1));
    plan.push_back(cfg_row(CFG_CELLS_DOWN, 40'd1));
    plan.push_back(cfg_row(CFG_SPREAD_LIMIT, 40'd0));
    plan.push_back(cfg_row(CFG_FAR_LIMIT, 40'hFFFFF));
    plan.push_back(pix_entry(20'h00001, 1'b0));
    plan.push_back(pix_entry(20'hFFFFE, 1'b0));
    plan.push_back(pix_entry(20'h00000, 1'b0));
    plan.push_back(pix_entry(20'hFFFFF, 1'b1, '{x: '0, y: '0, solid: 1'b1, done: 1'b1}));
    plan.push_back(cfg_row(CFG_SPREAD_LIMIT, 40'hFF_FFFF_FFFF));
    plan.push_back(pix_entry(20'h00001, 1'b0));
    plan.push_back(pix_entry(20'hFFFFE, 1'b0));
    plan.push_back(pix_entry(20'h00000, 1'b0));
    plan.push_back(pix_entry(20'hFFFFF, 1'b1, '{x: '0, y: '0, solid: 1'b0, done: 1'b1}));
    // Out-of-range geometry saturates to a 1x1 image
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 40'd0));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 40'd0));
    plan.push_back(cfg_row(CFG_CELLS_ACROSS, 40'd127));
    plan.push_back(cfg_row(CFG_CELLS_DOWN, 40'd8191));
    plan.push_back(pix_entry(20'h12345, 1'b1, '{x: '0, y: '0, solid: 1'b0, done: 1'b1}));
    plan.push_back(pix_entry(20'h00000, 1'b1, '{x: '0, y: '0, solid: 1'b0, done: 1'b1}));
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 40'd4096));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 40'd4096));
    plan.push_back(cfg_row(CFG_FAR_LIMIT, 40'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].depth, plan[i].typed, plan[i].want);
    end

    // Random geometries, thresholds and depth spreads
    while (pixels_sent < RandomItems) begin
      phases_run++;
      w  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      h  = $urandom_range(1, 12);
      ca = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) :
           $urandom_range(1, (w < GridColsMax) ? w : GridColsMax);
      cd = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, h);
      k  = $urandom_range(0, 19);
      base = $urandom_range(0, 20'hFFFFF);
      r64  = {$urandom, $urandom};
      sh   = (2 * k >= 4) ? 2 * k - 3 : 1;
      write_reg(CFG_IMAGE_WIDTH, CfgDataW'(w));
      write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(h));
      write_reg(CFG_CELLS_ACROSS, CfgDataW'(ca));
      write_reg(CFG_CELLS_DOWN, CfgDataW'(cd));
      write_reg(CFG_SPREAD_LIMIT, CfgDataW'(r64 & ((64'd1 << sh) - 1)));
      write_reg(CFG_FAR_LIMIT, ($urandom_range(0, 3) == 0) ?
                CfgDataW'($urandom_range(0, 20'hFFFFF)) : CfgDataW'(20'hFFFFF));
      burst_mode = ($urandom_range(0, 3) == 0);
      n_pix = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h);
      for (int i = 0; i < n_pix && pixels_sent < RandomItems; i++) begin
        case ($urandom_range(0, 15))
          0, 1:    d = '0;
          2, 3:    d = DepthW'($urandom);
          4:       d = 20'hFFFFF;
          default: d = DepthW'(base + $urandom_range(0, (1 << k) - 1));
        endcase
        send_pixel(d, 1'b0, '0);
      end
    end

    // Drain and report
    wait_idle();
    repeat (50) @(negedge clk_i);
    $display("covered directed extremes and %0d random geometries, %0d pixels",
             phases_run, pixels_sent);
    $display("%0d cells checked, receiver hold-off %0s", cells_seen, held_off ? "done" : "missed");
    if (errors == 0 && pending_cells.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
